FILE: hw/rtl/tlps_pkg.sv
package tlps_pkg;
  localparam int PROCESSES_DEF = 4;
  localparam int THREADS_PER_PROCESS_DEF = 4;
  localparam int PRIO_BITS_DEF = 8;

  typedef enum logic [2:0] {
    OP_SCHED = 3'd0,
    OP_WAKE  = 3'd1,
    OP_SLEEP = 3'd2,
    OP_PPRIO = 3'd3,
    OP_TPRIO = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DEC,
    ST_SCAN2,
    ST_DEC2,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic decide;
    logic decide2;
  } cmd_t;

  // status back to controller
  typedef struct packed {
    logic scan_done;
    logic need_decide;
    logic need_second;
  } sts_t;
endpackage

FILE: hw/rtl/two_level_priority_scheduler_unit.sv
// two-level priority scheduler: processes and their threads
// an item without a decision passes load, execute and result; a decision adds a scan and a
// decision step, maybe a second pair; one item at a time, set by the sequential entry scan
// the scan unit walks one process and one thread entry per cycle
// reset: synchronous active-low rst_n; all priorities 1, nothing runnable, idle
module two_level_priority_scheduler_unit #(
  parameter int PROCESSES = tlps_pkg::PROCESSES_DEF,
  parameter int THREADS_PER_PROCESS = tlps_pkg::THREADS_PER_PROCESS_DEF,
  parameter int PRIO_BITS = tlps_pkg::PRIO_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_thread_id,
  input  logic [1:0]  in_process_id,
  input  logic [7:0]  in_new_priority,
  input  logic [63:0] in_return_address,
  input  logic [63:0] in_watched_value,
  input  logic [63:0] in_expected_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_running,
  output logic [3:0]  out_selected_thread,
  output logic [1:0]  out_selected_process,
  output logic [63:0] out_resume_address,
  output logic        out_applied
);
  import tlps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: load, execute, optional scans and decisions, then result
  tlps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  // state tables, scan unit and result registers
  tlps_dp #(
    .PROCESSES(PROCESSES),
    .THREADS_PER_PROCESS(THREADS_PER_PROCESS),
    .PRIO_BITS(PRIO_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_thread_id(in_thread_id), .in_process_id(in_process_id),
    .in_new_priority(in_new_priority), .in_return_address(in_return_address),
    .in_watched_value(in_watched_value), .in_expected_value(in_expected_value),
    .out_running(out_running), .out_selected_thread(out_selected_thread),
    .out_selected_process(out_selected_process),
    .out_resume_address(out_resume_address), .out_applied(out_applied)
  );
endmodule

FILE: hw/rtl/tlps_ctrl.sv
module tlps_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output tlps_pkg::cmd_t cmd,
  input  tlps_pkg::sts_t sts
);
  import tlps_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = sts.need_decide ? ST_SCAN : ST_OUT;
        if (sts.need_decide) cmd.scan_start = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = ST_DEC;
      end
      ST_DEC: begin
        cmd.decide = 1'b1;
        if (sts.need_second) begin
          cmd.scan_start = 1'b1;
          state_nxt = ST_SCAN2;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SCAN2: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = ST_DEC2;
      end
      ST_DEC2: begin
        cmd.decide2 = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: hw/rtl/tlps_dp.sv
module tlps_dp #(
  parameter int PROCESSES = tlps_pkg::PROCESSES_DEF,
  parameter int THREADS_PER_PROCESS = tlps_pkg::THREADS_PER_PROCESS_DEF,
  parameter int PRIO_BITS = tlps_pkg::PRIO_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tlps_pkg::cmd_t cmd,
  output tlps_pkg::sts_t sts,
  input  logic [2:0]     in_op,
  input  logic [3:0]     in_thread_id,
  input  logic [1:0]     in_process_id,
  input  logic [7:0]     in_new_priority,
  input  logic [63:0]    in_return_address,
  input  logic [63:0]    in_watched_value,
  input  logic [63:0]    in_expected_value,
  output logic           out_running,
  output logic [3:0]     out_selected_thread,
  output logic [1:0]     out_selected_process,
  output logic [63:0]    out_resume_address,
  output logic           out_applied
);
  import tlps_pkg::*;

  localparam int NT = PROCESSES * THREADS_PER_PROCESS;
  localparam int TW = (NT > 1) ? $clog2(NT) : 1;
  localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int LW = (THREADS_PER_PROCESS > 1) ? $clog2(THREADS_PER_PROCESS) : 1;
  localparam int SW = (PROCESSES > THREADS_PER_PROCESS) ? PW : LW;
  localparam int SMAX = (PROCESSES > THREADS_PER_PROCESS) ? PROCESSES : THREADS_PER_PROCESS;
  localparam int CW = $clog2(SMAX + 1);

  logic [PRIO_BITS-1:0] tprio_r [NT];
  logic [NT-1:0]        trun_r, tq_r;
  logic [15:0]          tage_r [NT];
  logic [63:0]          tres_r [NT];
  logic [PRIO_BITS-1:0] pprio_r [PROCESSES];
  logic [PROCESSES-1:0] pq_r;
  logic [15:0]          page_r [PROCESSES];
  logic                 have_r, pend_r, applied_r;
  logic [TW-1:0]        ct_r;
  logic [PW-1:0]        cp_r;
  logic [15:0]          cnt_r;

  // latched item
  logic [2:0]  op_r;
  logic [7:0]  tid_r;
  logic [7:0]  pid_r;
  logic [7:0]  npri_r;
  logic [63:0] ra_r;
  logic        eq_r;

  // scan results: best process and head thread of one process
  logic [CW-1:0]        idx_r;
  logic [PW-1:0]        sp_r;
  logic                 spv_r;
  logic [TW-1:0]        st_r;
  logic                 stv_r;
  logic [PW-1:0]        scan_proc_r;

  function automatic logic [PRIO_BITS-1:0] clampp(input logic [7:0] v);
    logic [PRIO_BITS-1:0] q;
    q = PRIO_BITS'(v);
    return (q == '0) ? PRIO_BITS'(1) : q;
  endfunction

  // owning process by range compare against each process base
  function automatic logic [PW-1:0] proc_of(input logic [TW-1:0] t);
    logic [PW-1:0] r;
    r = '0;
    for (int p = 0; p < PROCESSES; p++)
      if (int'(t) >= p * THREADS_PER_PROCESS) r = PW'(p);
    return r;
  endfunction

  // any queued thread in process p
  function automatic logic pnonempty(input logic [NT-1:0] q, input logic [PW-1:0] p);
    logic r;
    r = 1'b0;
    for (int i = 0; i < THREADS_PER_PROCESS; i++)
      if (int'(p) * THREADS_PER_PROCESS + i < NT)
        r = r | q[int'(p) * THREADS_PER_PROCESS + i];
    return r;
  endfunction

  logic tok, pok;
  assign tok = {4'd0, tid_r} < 12'(NT);
  assign pok = {4'd0, pid_r} < 12'(PROCESSES);
  logic [TW-1:0] tid_t;
  assign tid_t = TW'(tid_r);
  logic [PW-1:0] tid_p;
  assign tid_p = proc_of(tid_t);

  logic need_dec;
  assign need_dec = (op_r == OP_SCHED) && pend_r;

  // scan element
  logic [SW-1:0] sidx;
  assign sidx = SW'(idx_r);
  logic [TW-1:0] cand_t;
  assign cand_t = TW'(int'(scan_proc_r) * THREADS_PER_PROCESS + int'(sidx));
  logic [PW-1:0] cand_p;
  assign cand_p = PW'(sidx);
  logic take_p, take_t, in_p, in_t;
  assign in_p = ({1'b0, idx_r} < (CW + 1)'(PROCESSES));
  assign in_t = ({1'b0, idx_r} < (CW + 1)'(THREADS_PER_PROCESS));
  always_comb begin
    take_p = 1'b0;
    take_t = 1'b0;
    if (in_p && pq_r[cand_p]) begin
      take_p = !spv_r || pprio_r[cand_p] > pprio_r[sp_r] ||
        (pprio_r[cand_p] == pprio_r[sp_r] &&
         (cnt_r - page_r[cand_p]) > (cnt_r - page_r[sp_r]));
    end
    if (in_t && tq_r[cand_t]) begin
      take_t = !stv_r || tprio_r[cand_t] > tprio_r[st_r] ||
        (tprio_r[cand_t] == tprio_r[st_r] &&
         (cnt_r - tage_r[cand_t]) > (cnt_r - tage_r[st_r]));
    end
  end

  // decision after first scan (head process and head thread of current)
  logic [PRIO_BITS-1:0] nppri, cppri, ctpri, ntpri;
  logic second;
  always_comb begin
    nppri = spv_r ? pprio_r[sp_r] : '0;
    cppri = pprio_r[cp_r];
    ctpri = trun_r[ct_r] ? tprio_r[ct_r] : '0;
    ntpri = stv_r ? tprio_r[st_r] : '0;
    second = 1'b0;
    if (have_r && cppri >= nppri) begin
      if (!(ctpri != '0 && ctpri >= ntpri) && ntpri == '0) second = nppri > '0;
    end else begin
      second = nppri > (have_r ? cppri : '0);
    end
  end

  assign sts.scan_done = ({1'b0, idx_r} >= (CW + 1)'(SMAX - 1));
  assign sts.need_decide = need_dec;
  assign sts.need_second = second;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) begin
        tprio_r[i] <= PRIO_BITS'(1);
        tage_r[i] <= '0;
        tres_r[i] <= '0;
      end
      for (int i = 0; i < PROCESSES; i++) begin
        pprio_r[i] <= PRIO_BITS'(1);
        page_r[i] <= '0;
      end
      trun_r <= '0;
      tq_r <= '0;
      pq_r <= '0;
      have_r <= 1'b0;
      pend_r <= 1'b0;
      applied_r <= 1'b0;
      ct_r <= '0;
      cp_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
      spv_r <= 1'b0;
      stv_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r <= in_op;
        tid_r <= {4'd0, in_thread_id};
        pid_r <= {6'd0, in_process_id};
        npri_r <= in_new_priority;
        ra_r <= in_return_address;
        eq_r <= in_watched_value == in_expected_value;
      end
      if (cmd.exec) begin
        applied_r <= 1'b0;
        case (op_r)
          OP_SCHED: begin
            if (have_r) tres_r[ct_r] <= ra_r;
            if (pend_r) begin
              applied_r <= 1'b1;
              pend_r <= 1'b0;
            end
          end
          OP_WAKE: begin
            if (tok && !trun_r[tid_t]) begin
              trun_r[tid_t] <= 1'b1;
              pend_r <= 1'b1;
              applied_r <= 1'b1;
              if (!pnonempty(tq_r, tid_p) && !pq_r[tid_p]) begin
                pq_r[tid_p] <= 1'b1;
                page_r[tid_p] <= cnt_r;
                if (!tq_r[tid_t]) begin
                  tq_r[tid_t] <= 1'b1;
                  tage_r[tid_t] <= cnt_r + 16'd1;
                  cnt_r <= cnt_r + 16'd2;
                end else begin
                  cnt_r <= cnt_r + 16'd1;
                end
              end else if (!tq_r[tid_t]) begin
                tq_r[tid_t] <= 1'b1;
                tage_r[tid_t] <= cnt_r;
                cnt_r <= cnt_r + 16'd1;
              end
            end
          end
          OP_SLEEP: begin
            if (tok && trun_r[tid_t] && eq_r) begin
              logic [NT-1:0] nq;
              nq = tq_r;
              nq[tid_t] = 1'b0;
              trun_r[tid_t] <= 1'b0;
              tq_r <= nq;
              pend_r <= 1'b1;
              applied_r <= 1'b1;
              if (!pnonempty(nq, tid_p)) pq_r[tid_p] <= 1'b0;
            end
          end
          OP_PPRIO: begin
            if (pok) begin
              pprio_r[PW'(pid_r)] <= clampp(npri_r);
              if (pq_r[PW'(pid_r)]) begin
                page_r[PW'(pid_r)] <= cnt_r;
                cnt_r <= cnt_r + 16'd1;
              end
              pend_r <= 1'b1;
              applied_r <= 1'b1;
            end
          end
          OP_TPRIO: begin
            if (tok) begin
              tprio_r[tid_t] <= clampp(npri_r);
              if (tq_r[tid_t]) begin
                tage_r[tid_t] <= cnt_r;
                cnt_r <= cnt_r + 16'd1;
              end
              pend_r <= 1'b1;
              applied_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan_start) begin
        idx_r <= '0;
        spv_r <= 1'b0;
        stv_r <= 1'b0;
        if (cmd.exec) scan_proc_r <= cp_r;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + CW'(1);
        if (take_p) begin
          sp_r <= cand_p;
          spv_r <= 1'b1;
        end
        if (take_t) begin
          st_r <= cand_t;
          stv_r <= 1'b1;
        end
      end
      if (cmd.decide) begin
        if (have_r && cppri >= nppri && ctpri != '0 && ctpri >= ntpri) begin
          // keep current
        end else if (have_r && cppri >= nppri && ntpri != '0) begin
          // switch within process; current thread goes back in first
          logic [TW-1:0] h;
          h = st_r;
          if (ctpri != '0 && !tq_r[ct_r]) begin
            if (tprio_r[ct_r] > tprio_r[st_r]) h = ct_r;
            tage_r[ct_r] <= cnt_r;
            cnt_r <= cnt_r + 16'd1;
            tq_r[ct_r] <= (h != ct_r);
          end
          tq_r[h] <= 1'b0;
          ct_r <= h;
          cp_r <= proc_of(h);
        end else if (second) begin
          // current thread and process go back, then the best process
          logic [15:0] c;
          logic [PW-1:0] np;
          c = cnt_r;
          np = sp_r;
          if (have_r && trun_r[ct_r] && !tq_r[ct_r]) begin
            tq_r[ct_r] <= 1'b1;
            tage_r[ct_r] <= c;
            c = c + 16'd1;
          end
          if (have_r && (stv_r || trun_r[ct_r]) && !pq_r[cp_r]) begin
            page_r[cp_r] <= c;
            c = c + 16'd1;
            if (pprio_r[cp_r] > pprio_r[sp_r]) np = cp_r;
            pq_r[cp_r] <= (np != cp_r);
          end
          cnt_r <= c;
          pq_r[np] <= 1'b0;
          sp_r <= np;
          scan_proc_r <= np;
          have_r <= 1'b0;
        end else begin
          have_r <= 1'b0;
          ct_r <= '0;
          cp_r <= '0;
        end
      end
      if (cmd.decide2) begin
        if (stv_r) begin
          tq_r[st_r] <= 1'b0;
          have_r <= 1'b1;
          ct_r <= st_r;
          cp_r <= proc_of(st_r);
        end else begin
          have_r <= 1'b0;
          ct_r <= '0;
          cp_r <= '0;
        end
      end
    end
  end

  assign out_running = have_r;
  assign out_selected_thread = have_r ? 4'(ct_r) : 4'd0;
  assign out_selected_process = have_r ? 2'(cp_r) : 2'd0;
  assign out_resume_address = have_r ? tres_r[ct_r] : 64'd0;
  assign out_applied = applied_r;
endmodule
